>>> src/bdpd_pkg.sv
// Package for the button debounce core: transaction types, register indexes and constants.
package bdpd_pkg;

  localparam int unsigned CountWidth  = 8;
  localparam int unsigned TimeWidth   = 32;
  localparam int unsigned ThreshWidth = 16;
  localparam int unsigned LevelWidth  = 4;

  // Level and event bit positions
  localparam int unsigned LvlHeld     = 0;
  localparam int unsigned LvlLong     = 1;
  localparam int unsigned LvlLonger   = 2;
  localparam int unsigned LvlVeryLong = 3;

  localparam logic [LevelWidth-1:0] LevelsNone     = 4'b0000;
  localparam logic [LevelWidth-1:0] LevelsHeld     = 4'b0001;
  localparam logic [LevelWidth-1:0] LevelsLong     = 4'b0011;
  localparam logic [LevelWidth-1:0] LevelsLonger   = 4'b0111;
  localparam logic [LevelWidth-1:0] LevelsVeryLong = 4'b1111;

  // Register reset values
  localparam logic [CountWidth-1:0]  DebounceReset = 8'd5;
  localparam logic [ThreshWidth-1:0] LongReset     = 16'd1000;
  localparam logic [ThreshWidth-1:0] LongerReset   = 16'd2000;
  localparam logic [ThreshWidth-1:0] VeryLongReset = 16'd8000;

  typedef enum logic [7:0] {
    REG_DEBOUNCE  = 8'd0,
    REG_LONG      = 8'd1,
    REG_LONGER    = 8'd2,
    REG_VERY_LONG = 8'd3
  } cfg_index_t;

  typedef struct packed {
    logic                 pin_level;
    logic [TimeWidth-1:0] now_ms;
    logic                 ack_release;
    logic                 soft_reset;
  } sample_t;

  typedef struct packed {
    logic pressed_now;
    logic held;
    logic held_long;
    logic held_longer;
    logic held_very_long;
    logic released_short;
    logic released_long;
    logic released_longer;
    logic released_very_long;
  } result_t;

endpackage

>>> src/button_debounce_press_duration_core.sv
// Top level of the button debounce core with press duration levels and release events.
//
// Usage:
//   Sample channel (sample_valid/sample_ready/sample): one transaction per raw pin
//   sample with its millisecond timestamp. Pin low means pressed.
//   Result channel (result_valid/result_ready/result): one transaction per sample,
//   showing the debounce status, the held levels and the latched release events.
//   Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready; write
//   registers only while no sample is in flight. Unknown indexes are dropped.
//   Output: the result is registered and appears in the cycle after the sample is accepted.
//   Throughput: one sample per cycle while results are taken; the elapsed-time subtract and three
//   threshold compares sit between the sample port and the result register.
//   Stall: while result_valid is high and result_ready is low, the result holds
//   and sample_ready drops; when the result is taken a new sample is accepted in
//   the same cycle.
//   Reset: clears the press state and the result slot and restores the register
//   defaults (debounce 5, thresholds 1000, 2000 and 8000 ms).
module button_debounce_press_duration_core
  import bdpd_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  sample_t                sample,
  output logic                   result_valid,
  input  logic                   result_ready,
  output result_t                result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_index,
  input  logic [ThreshWidth-1:0] cfg_data
);

  // Configuration registers
  logic [CountWidth-1:0]  debounce_count;
  logic [ThreshWidth-1:0] long_threshold_ms;
  logic [ThreshWidth-1:0] longer_threshold_ms;
  logic [ThreshWidth-1:0] very_long_threshold_ms;

  // Press state
  logic [CountWidth-1:0] press_count, press_count_next;
  logic [TimeWidth-1:0]  press_start_time, press_start_time_next;
  logic [LevelWidth-1:0] held_levels, held_levels_next;
  logic [LevelWidth-1:0] release_events, release_events_next;

  logic [TimeWidth-1:0]  elapsed;
  logic [LevelWidth-1:0] levels_now;
  logic [LevelWidth-1:0] top_level;
  logic                  count_full;
  logic                  accept;
  result_t               result_next;

  assign cfg_ready    = 1'b1;
  assign sample_ready = !result_valid || result_ready;
  assign accept       = sample_valid && sample_ready;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count         <= DebounceReset;
      long_threshold_ms      <= LongReset;
      longer_threshold_ms    <= LongerReset;
      very_long_threshold_ms <= VeryLongReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index_t'(cfg_index))
        REG_DEBOUNCE:  debounce_count         <= cfg_data[CountWidth-1:0];
        REG_LONG:      long_threshold_ms      <= cfg_data;
        REG_LONGER:    longer_threshold_ms    <= cfg_data;
        REG_VERY_LONG: very_long_threshold_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // Elapsed time wraps modulo 2^32; thresholds are zero-extended
  assign elapsed = sample.now_ms - press_start_time;

  always_comb begin
    if (elapsed > {{(TimeWidth-ThreshWidth){1'b0}}, very_long_threshold_ms}) begin
      levels_now = LevelsVeryLong;
    end else if (elapsed > {{(TimeWidth-ThreshWidth){1'b0}}, longer_threshold_ms}) begin
      levels_now = LevelsLonger;
    end else if (elapsed > {{(TimeWidth-ThreshWidth){1'b0}}, long_threshold_ms}) begin
      levels_now = LevelsLong;
    end else begin
      levels_now = LevelsHeld;
    end
  end

  // One event for the highest level reached
  always_comb begin
    top_level = LevelsNone;
    if (held_levels[LvlVeryLong]) begin
      top_level[LvlVeryLong] = 1'b1;
    end else if (held_levels[LvlLonger]) begin
      top_level[LvlLonger] = 1'b1;
    end else if (held_levels[LvlLong]) begin
      top_level[LvlLong] = 1'b1;
    end else if (held_levels[LvlHeld]) begin
      top_level[LvlHeld] = 1'b1;
    end
  end

  assign count_full = (press_count == debounce_count);

  always_comb begin
    press_count_next      = press_count;
    press_start_time_next = press_start_time;
    held_levels_next      = held_levels;
    release_events_next   = release_events;
    if (sample.soft_reset) begin
      press_count_next    = '0;
      held_levels_next    = LevelsNone;
      release_events_next = LevelsNone;
    end else if (!sample.pin_level) begin
      if (press_count < debounce_count) begin
        // Cannot overflow: the count stays below debounce_count
        press_count_next = press_count + 1'b1;
        if (press_count_next == debounce_count) begin
          press_start_time_next = sample.now_ms;
        end
      end else begin
        held_levels_next = levels_now;
      end
    end else begin
      // Release: latch the event only after a debounced press
      if (count_full) begin
        release_events_next = top_level;
      end
      held_levels_next = LevelsNone;
      press_count_next = '0;
    end

    result_next.pressed_now        = (press_count_next == debounce_count);
    result_next.held               = held_levels_next[LvlHeld];
    result_next.held_long          = held_levels_next[LvlLong];
    result_next.held_longer        = held_levels_next[LvlLonger];
    result_next.held_very_long     = held_levels_next[LvlVeryLong];
    result_next.released_short     = release_events_next[LvlHeld];
    result_next.released_long      = release_events_next[LvlLong];
    result_next.released_longer    = release_events_next[LvlLonger];
    result_next.released_very_long = release_events_next[LvlVeryLong];
  end

  // Advance the press state on each accepted sample; the ack clears events after reporting
  always_ff @(posedge clk) begin
    if (rst) begin
      press_count      <= '0;
      press_start_time <= '0;
      held_levels      <= LevelsNone;
      release_events   <= LevelsNone;
    end else if (accept) begin
      press_count      <= press_count_next;
      press_start_time <= press_start_time_next;
      held_levels      <= held_levels_next;
      release_events   <= sample.ack_release ? LevelsNone : release_events_next;
    end
  end

  // Result slot: hold while stalled, load on accept
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result <= result_next;
    end
  end

endmodule

>>> test/tb.sv
// Self-checking testbench for the button debounce core: directed table, random press bursts, scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bdpd_pkg::*;

  // Cycles with no transaction on any channel before the run is declared hung.
  localparam int WatchdogCycles = 2000;
  // Cap on printed mismatch lines; every mismatch is still counted.
  localparam int MaxPrinted = 40;
  // Index past the register map; such writes must be dropped.
  localparam logic [7:0] UnmappedIndex = 8'hFF;

  localparam result_t ResultClear = '0;

  // One row of the directed table: a sample, plus a typed expectation where it is
  // plain to see; rows with known low are checked against the predictor.
  typedef struct packed {
    sample_t smp;
    logic    known;
    result_t want;
  } dir_row_t;

  localparam int DirRows = 21;
  localparam dir_row_t DIRECTED [DirRows] = '{
    // released pin straight out of reset: nothing counted, nothing latched
    '{'{1'b1, 32'd0, 1'b0, 1'b0}, 1'b1, ResultClear},
    // soft reset with every other field at its extreme: sample ignored
    '{'{1'b0, 32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b1, ResultClear},
    // five pressed samples reach the default debounce; start time 0xFFFFFF04
    '{'{1'b0, 32'hFFFF_FF00, 1'b0, 1'b0}, 1'b0, ResultClear},
    '{'{1'b0, 32'hFFFF_FF01, 1'b0, 1'b0}, 1'b0, ResultClear},
    '{'{1'b0, 32'hFFFF_FF02, 1'b0, 1'b0}, 1'b0, ResultClear},
    '{'{1'b0, 32'hFFFF_FF03, 1'b0, 1'b0}, 1'b0, ResultClear},
    '{'{1'b0, 32'hFFFF_FF04, 1'b0, 1'b0}, 1'b0, ResultClear},
    // elapsed exactly 1000 across the wrap: equal is not beyond, held only
    '{'{1'b0, 32'd748, 1'b0, 1'b0}, 1'b0, ResultClear},
    // one past each threshold: long, longer, very long
    '{'{1'b0, 32'd749, 1'b0, 1'b0}, 1'b0, ResultClear},
    '{'{1'b0, 32'd1749, 1'b0, 1'b0}, 1'b0, ResultClear},
    '{'{1'b0, 32'd7749, 1'b0, 1'b0}, 1'b0, ResultClear},
    // release latches the very long event, left unacknowledged
    '{'{1'b1, 32'd7750, 1'b0, 1'b0}, 1'b0, ResultClear},
    // bounce that never debounces: the latched event survives, then gets acked
    '{'{1'b0, 32'd7751, 1'b0, 1'b0}, 1'b0, ResultClear},
    '{'{1'b1, 32'd7752, 1'b1, 1'b0}, 1'b0, ResultClear},
    // debounce, then release before any held sample: no event
    '{'{1'b0, 32'd7753, 1'b0, 1'b0}, 1'b0, ResultClear},
    '{'{1'b0, 32'd7754, 1'b0, 1'b0}, 1'b0, ResultClear},
    '{'{1'b0, 32'd7755, 1'b0, 1'b0}, 1'b0, ResultClear},
    '{'{1'b0, 32'd7756, 1'b0, 1'b0}, 1'b0, ResultClear},
    '{'{1'b0, 32'd7757, 1'b0, 1'b0}, 1'b0, ResultClear},
    '{'{1'b1, 32'd7758, 1'b0, 1'b0}, 1'b0, ResultClear},
    // soft reset while pressed: cleared, debounce 5 so not pressed_now
    '{'{1'b0, 32'd7759, 1'b1, 1'b1}, 1'b1, ResultClear}
  };

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   sample_valid = 1'b0;
  logic                   sample_ready;
  sample_t                sample = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [7:0]             cfg_index = '0;
  logic [ThreshWidth-1:0] cfg_data = '0;

  // Typed expectation that travels with the sample on the wire.
  logic    row_known = 1'b0;
  result_t row_want = '0;

  // High while neither side may idle.
  bit steady = 1'b0;

  // Predictor copy of the registers and the press state.
  logic [CountWidth-1:0]  deb_target;
  logic [ThreshWidth-1:0] thr_long;
  logic [ThreshWidth-1:0] thr_longer;
  logic [ThreshWidth-1:0] thr_very;
  logic [CountWidth-1:0]  press_cnt;
  logic [TimeWidth-1:0]   press_t0;
  logic [LevelWidth-1:0]  held_lv;
  logic [LevelWidth-1:0]  rel_evt;

  result_t awaited_status[$];

  logic [TimeWidth-1:0] clock_ms = '0;
  int n_sent = 0;
  int n_checked = 0;
  int n_errors = 0;
  int n_settings = 1;
  int idle_cycles = 0;

  button_debounce_press_duration_core DUT (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Apply one sample to the predicted press state and return the status it reports.
  function automatic result_t advance_button(input sample_t s);
    result_t              r;
    logic [TimeWidth-1:0] elapsed;
    if (s.soft_reset) begin
      press_cnt = '0;
      held_lv   = LevelsNone;
      rel_evt   = '0;
    end else if (!s.pin_level) begin
      if (press_cnt < deb_target) begin
        press_cnt = press_cnt + 1'b1;
        // Record the press start on the sample that completes the debounce.
        if (press_cnt == deb_target) press_t0 = s.now_ms;
      end else begin
        elapsed = s.now_ms - press_t0;
        // Test from the top down; the first threshold exceeded sets the chain below it.
        if (elapsed > {16'd0, thr_very}) held_lv = LevelsVeryLong;
        else if (elapsed > {16'd0, thr_longer}) held_lv = LevelsLonger;
        else if (elapsed > {16'd0, thr_long}) held_lv = LevelsLong;
        else held_lv = LevelsHeld;
      end
    end else begin
      // Latch only the highest level reached, and only after a debounced press.
      if (press_cnt == deb_target) begin
        rel_evt = '0;
        if (held_lv[LvlVeryLong]) rel_evt[LvlVeryLong] = 1'b1;
        else if (held_lv[LvlLonger]) rel_evt[LvlLonger] = 1'b1;
        else if (held_lv[LvlLong]) rel_evt[LvlLong] = 1'b1;
        else if (held_lv[LvlHeld]) rel_evt[LvlHeld] = 1'b1;
      end
      held_lv   = LevelsNone;
      press_cnt = '0;
    end
    r.pressed_now        = (press_cnt == deb_target);
    r.held               = held_lv[LvlHeld];
    r.held_long          = held_lv[LvlLong];
    r.held_longer        = held_lv[LvlLonger];
    r.held_very_long     = held_lv[LvlVeryLong];
    r.released_short     = rel_evt[LvlHeld];
    r.released_long      = rel_evt[LvlLong];
    r.released_longer    = rel_evt[LvlLonger];
    r.released_very_long = rel_evt[LvlVeryLong];
    // The ack clears after the report, so it shows in the next result only.
    if (s.ack_release) rel_evt = '0;
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (n_errors < MaxPrinted) $display("[%0t] MISMATCH: %s", $realtime, what);
    n_errors++;
  endtask

  task automatic check_field(input string field, input logic got, input logic want);
    if (got !== want)
      report_mismatch($sformatf("result %0d, %s: got %b, expected %b",
                                n_checked, field, got, want));
  endtask

  // Scoreboard and watchdog: sample at the rising edge, where every input
  // driven at the falling edge has settled and no register has moved yet.
  always @(posedge clk) begin
    result_t want;
    logic    progress;
    if (rst) begin
      deb_target  = DebounceReset;
      thr_long    = LongReset;
      thr_longer  = LongerReset;
      thr_very    = VeryLongReset;
      press_cnt   = '0;
      press_t0    = '0;
      held_lv     = LevelsNone;
      rel_evt     = '0;
      idle_cycles = 0;
    end else begin
      progress = 1'b0;
      // Check first: a result taken here belongs to an earlier sample.
      if (result_valid && result_ready) begin
        progress = 1'b1;
        if (awaited_status.size() == 0) begin
          report_mismatch("result transaction with no sample outstanding");
        end else begin
          want = awaited_status.pop_front();
          check_field("pressed_now", result.pressed_now, want.pressed_now);
          check_field("held", result.held, want.held);
          check_field("held_long", result.held_long, want.held_long);
          check_field("held_longer", result.held_longer, want.held_longer);
          check_field("held_very_long", result.held_very_long, want.held_very_long);
          check_field("released_short", result.released_short, want.released_short);
          check_field("released_long", result.released_long, want.released_long);
          check_field("released_longer", result.released_longer, want.released_longer);
          check_field("released_very_long", result.released_very_long,
                      want.released_very_long);
          n_checked++;
        end
      end
      if (sample_valid && sample_ready) begin
        progress = 1'b1;
        want = advance_button(sample);
        // Advance the predictor always; a typed row overrides what is awaited.
        awaited_status.push_back(row_known ? row_want : want);
      end
      if (cfg_valid && cfg_ready) begin
        progress = 1'b1;
        case (cfg_index)
          REG_DEBOUNCE:  deb_target = cfg_data[CountWidth-1:0];
          REG_LONG:      thr_long   = cfg_data;
          REG_LONGER:    thr_longer = cfg_data;
          REG_VERY_LONG: thr_very   = cfg_data;
          default: ;
        endcase
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= WatchdogCycles) begin
        $display("Watchdog: no transaction for %0d cycles", WatchdogCycles);
        $display("button_debounce_press_duration_core test failed");
        $finish;
      end
    end
  end

  // Stall the result side about one time in five, except in steady stretches.
  always @(negedge clk) begin
    result_ready <= steady ? 1'b1 : ($urandom_range(99) >= 19);
  end

  // Drive one sample: maybe idle first, then hold it until accepted.
  task automatic send_sample(input logic pin, input logic [TimeWidth-1:0] now,
                             input logic ack, input logic srst,
                             input logic known, input result_t want);
    @(negedge clk);
    if (!steady && $urandom_range(99) < 19) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= '{pin_level: pin, now_ms: now, ack_release: ack, soft_reset: srst};
    row_known    <= known;
    row_want     <= want;
    do @(posedge clk); while (!sample_ready);
    n_sent++;
  endtask

  // Drop valid and wait until every awaited result is in, then pause for the result register to empty.
  task automatic settle();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (awaited_status.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [7:0] idx, input logic [ThreshWidth-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Quiesce, then program all four registers. Only the low byte of the
  // debounce word counts; the upper byte is there to toggle the bus.
  task automatic load_settings(input logic [ThreshWidth-1:0] deb_word,
                               input logic [ThreshWidth-1:0] lng_ms,
                               input logic [ThreshWidth-1:0] lngr_ms,
                               input logic [ThreshWidth-1:0] vlng_ms);
    settle();
    write_reg(REG_DEBOUNCE, deb_word);
    write_reg(REG_LONG, lng_ms);
    write_reg(REG_LONGER, lngr_ms);
    write_reg(REG_VERY_LONG, vlng_ms);
    n_settings++;
  endtask

  // Mostly well-formed presses: debounce run, a held stretch whose steps are
  // scaled to the largest threshold, then a release. The rest is raw noise.
  task automatic run_phase(input int budget);
    int start_n;
    int need;
    int hold_n;
    int step_max;
    logic [ThreshWidth-1:0] top_thr;
    start_n = n_sent;
    while (n_sent - start_n < budget) begin
      if ($urandom_range(9) < 8) begin
        need    = int'(deb_target);
        hold_n  = $urandom_range(0, 6);
        top_thr = thr_long;
        if (thr_longer > top_thr) top_thr = thr_longer;
        if (thr_very > top_thr) top_thr = thr_very;
        step_max = (hold_n == 0) ? 1 : (2 * int'(top_thr)) / hold_n + 2;
        // Now and then start just below the wrap so elapsed time crosses it.
        if ($urandom_range(7) == 0)
          clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 3 * int'(top_thr));
        for (int k = 0; k < need + hold_n; k++) begin
          clock_ms += (k < need) ? $urandom_range(0, 3) : $urandom_range(0, step_max);
          send_sample(1'b0, clock_ms, 1'($urandom_range(1)), $urandom_range(39) == 0,
                      1'b0, ResultClear);
        end
        repeat ($urandom_range(1, 2)) begin
          clock_ms += $urandom_range(0, 50);
          send_sample(1'b1, clock_ms, 1'($urandom_range(1)), $urandom_range(39) == 0,
                      1'b0, ResultClear);
        end
      end else begin
        repeat ($urandom_range(1, 4))
          send_sample(1'($urandom_range(1)), $urandom(), 1'($urandom_range(1)),
                      $urandom_range(7) == 0, 1'b0, ResultClear);
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed table under the reset register values.
    for (int r = 0; r < DirRows; r++)
      send_sample(DIRECTED[r].smp.pin_level, DIRECTED[r].smp.now_ms,
                  DIRECTED[r].smp.ack_release, DIRECTED[r].smp.soft_reset,
                  DIRECTED[r].known, DIRECTED[r].want);

    // Lowest thresholds, debounce 1: every elapsed tick beyond zero is very long.
    load_settings(16'h0001, 16'd0, 16'd0, 16'd0);
    write_reg(UnmappedIndex, 16'hFFFF);
    clock_ms = $urandom();
    run_phase(150);

    // Highest settings, run as one stretch with no idling on either side.
    load_settings(16'hA5FF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    steady = 1'b1;
    run_phase(100);
    steady = 1'b0;

    // Zero debounce: every pressed sample takes the held path.
    load_settings(16'h5A00, 16'd300, 16'd700, 16'd1500);
    run_phase(150);

    // Unordered thresholds: levels still nest by the top-down test.
    load_settings(16'h0003, 16'd5000, 16'd100, 16'd2500);
    run_phase(150);

    // Random register settings, each with a write past the map.
    for (int p = 0; p < 4; p++) begin
      load_settings({8'($urandom_range(255)), 8'($urandom_range(1, 8))},
                    16'($urandom), 16'($urandom), 16'($urandom_range(0, 3000)));
      write_reg(8'($urandom_range(int'(REG_VERY_LONG) + 1, 255)), 16'($urandom));
      run_phase(120);
    end

    // Lower the debounce below a count already in progress.
    load_settings(16'h0006, 16'd200, 16'd400, 16'd800);
    send_sample(1'b1, clock_ms, 1'b0, 1'b0, 1'b0, ResultClear);
    repeat (4) begin
      clock_ms += 1;
      send_sample(1'b0, clock_ms, 1'b0, 1'b0, 1'b0, ResultClear);
    end
    settle();
    write_reg(REG_DEBOUNCE, 16'h0002);
    run_phase(80);

    // Drain, then idle so that any stray result from the block would show.
    settle();
    repeat (4) @(negedge clk);

    $display("Summary: %0d samples, %0d results checked, %0d register settings",
             n_sent, n_checked, n_settings);
    $display("Covered: wrapped timestamps, zero and lowered debounce, unordered thresholds");
    if (n_errors == 0) begin
      $display("button_debounce_press_duration_core test passed");
    end else begin
      $display("button_debounce_press_duration_core test failed");
    end
    $finish;
  end

endmodule
